// ===== rtl/core/vatf_pkg.sv =====
// Package for the vertex attribute to float core: types, codes and the
// channel conversion tables. No dependencies.
`default_nettype none
package vatf_pkg;

	localparam logic OP_COMP  = 1'b0;
	localparam logic OP_COLOR = 1'b1;

	localparam logic [2:0] CF_U8  = 3'd0;
	localparam logic [2:0] CF_S8  = 3'd1;
	localparam logic [2:0] CF_U16 = 3'd2;
	localparam logic [2:0] CF_S16 = 3'd3;

	localparam logic [2:0] KF_RGB565 = 3'd0;
	localparam logic [2:0] KF_RGB8   = 3'd1;
	localparam logic [2:0] KF_RGBX8  = 3'd2;
	localparam logic [2:0] KF_RGBA4  = 3'd3;
	localparam logic [2:0] KF_RGBA6  = 3'd4;

	localparam logic [31:0] FP_ONE = 32'h3f80_0000;

	localparam int unsigned IN_W  = 48;
	localparam int unsigned OUT_W = 136;

	typedef struct packed {
		logic        opcode;
		logic [31:0] raw_bytes;
		logic [2:0]  format;
		logic [4:0]  frac;
	} item_t;

	typedef struct packed {
		logic [2:0]  bytes_used;
		logic [31:0] value3;
		logic [31:0] value2;
		logic [31:0] value1;
		logic [31:0] value0;
	} result_t;

	// 256-entry table of singles, indexed by the channel code
	typedef logic [255:0][31:0] lut_t;

	// Correctly rounded n/(2^k-1) as an IEEE single. The quotient lies in
	// [2^(e-127), 2^(e-126)); mantissa computed with 24 fraction bits then RNE.
	// The quotient is never exactly halfway (denominator odd, not power of 2).
	function automatic logic [31:0] unorm_to_float(input logic [7:0] n,
		input logic [3:0] k);
		logic [7:0]  dmax;
		logic [39:0] num;
		logic [39:0] q;
		logic [39:0] r;
		logic [7:0]  e;
		logic [23:0] m;
		logic        rb;
		logic [24:0] mr;
		int          lz;
		dmax = 8'((9'd1 << k) - 9'd1);
		if (n == 8'd0) return 32'd0;
		if (n == dmax) return FP_ONE;
		// normalize: find shift so that n*2^s / dmax in [1,2)
		lz = 0;
		for (int s = 1; s <= 8; s++) begin
			if (lz == 0 && ({24'd0, n} << s) >= {24'd0, dmax}) lz = s;
		end
		num = 40'(n) << (lz + 24);
		q = num / 40'(dmax);
		r = num - q * 40'(dmax);
		m = q[24:1];
		rb = q[0];
		mr = {1'b0, m} + 25'(rb);
		e = 8'(127 - lz);
		if (r == 40'd0 && rb) mr = {1'b0, m} + 25'(m[0]);
		return {1'b0, e, mr[22:0]};
	endfunction

	// Fill one table for a k-bit channel; codes past 2^k-1 stay zero.
	function automatic lut_t build_lut(input logic [3:0] k);
		lut_t t;
		t = '0;
		for (int i = 0; i < 256; i++) begin
			if (i < (1 << k)) t[i] = unorm_to_float(8'(i), k);
		end
		return t;
	endfunction

	localparam lut_t LUT_K4 = build_lut(4'd4);
	localparam lut_t LUT_K5 = build_lut(4'd5);
	localparam lut_t LUT_K6 = build_lut(4'd6);
	localparam lut_t LUT_K8 = build_lut(4'd8);

	// Constant tables: 8-bit index per channel width.
	function automatic logic [31:0] chan_lut(input logic [7:0] n,
		input logic [3:0] k);
		logic [31:0] v;
		unique case (k)
			4'd4:    v = LUT_K4[n];
			4'd5:    v = LUT_K5[n];
			4'd6:    v = LUT_K6[n];
			default: v = LUT_K8[n];
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/vatf_comp.sv =====
// Component dequantizer: u8/s8/u16/s16 to exact single scaled by 2^-frac,
// f32 pass-through. Depends on vatf_pkg.
`default_nettype none
module vatf_comp (
	input  wire logic [31:0] raw_bytes,
	input  wire logic [2:0]  format,
	input  wire logic [4:0]  frac,
	output logic      [31:0] value,
	output logic      [2:0]  bytes_used
);
	logic        is_int;
	logic        neg;
	logic [15:0] mag;
	logic [4:0]  msb;
	logic [7:0]  expo;
	logic [22:0] mant;

	// select integer and magnitude
	always_comb begin
		is_int = 1'b1;
		neg = 1'b0;
		mag = 16'd0;
		bytes_used = 3'd4;
		unique case (format)
			vatf_pkg::CF_U8: begin
				mag = {8'd0, raw_bytes[31:24]};
				bytes_used = 3'd1;
			end
			vatf_pkg::CF_S8: begin
				neg = raw_bytes[31];
				mag = raw_bytes[31] ? 16'(8'(-raw_bytes[31:24])) : {8'd0, raw_bytes[31:24]};
				if (raw_bytes[31:24] == 8'h80) mag = 16'h0080;
				bytes_used = 3'd1;
			end
			vatf_pkg::CF_U16: begin
				mag = raw_bytes[31:16];
				bytes_used = 3'd2;
			end
			vatf_pkg::CF_S16: begin
				neg = raw_bytes[31];
				mag = raw_bytes[31] ? 16'(-raw_bytes[31:16]) : raw_bytes[31:16];
				bytes_used = 3'd2;
			end
			default: is_int = 1'b0;
		endcase
	end

	// leading one search over 16 bits, then pack
	always_comb begin
		msb = 5'd0;
		for (int i = 0; i < 16; i++) begin
			if (mag[i]) msb = 5'(i);
		end
		expo = 8'(8'd127 + {3'd0, msb} - {3'd0, frac});
		mant = 23'({7'd0, mag} << (5'd23 - msb));
		if (!is_int) value = raw_bytes;
		else if (mag == 16'd0) value = 32'd0;
		else value = {neg, expo, mant};
	end
endmodule
`default_nettype wire

// ===== rtl/core/vatf_color.sv =====
// Colour expander: packed colour formats to four IEEE singles in [0,1].
// Depends on vatf_pkg (conversion tables).
`default_nettype none
module vatf_color (
	input  wire logic [31:0] raw_bytes,
	input  wire logic [2:0]  format,
	output logic      [31:0] v0,
	output logic      [31:0] v1,
	output logic      [31:0] v2,
	output logic      [31:0] v3,
	output logic      [2:0]  bytes_used
);
	logic [15:0] w16;
	logic [23:0] w24;

	assign w16 = raw_bytes[31:16];
	assign w24 = raw_bytes[31:8];

	// channel extraction and table lookup
	always_comb begin
		v3 = vatf_pkg::FP_ONE;
		unique case (format)
			vatf_pkg::KF_RGB565: begin
				v0 = vatf_pkg::chan_lut({3'd0, w16[15:11]}, 4'd5);
				v1 = vatf_pkg::chan_lut({2'd0, w16[10:5]}, 4'd6);
				v2 = vatf_pkg::chan_lut({3'd0, w16[4:0]}, 4'd5);
				bytes_used = 3'd2;
			end
			vatf_pkg::KF_RGB8, vatf_pkg::KF_RGBX8: begin
				v0 = vatf_pkg::chan_lut(raw_bytes[31:24], 4'd8);
				v1 = vatf_pkg::chan_lut(raw_bytes[23:16], 4'd8);
				v2 = vatf_pkg::chan_lut(raw_bytes[15:8], 4'd8);
				bytes_used = (format == vatf_pkg::KF_RGB8) ? 3'd3 : 3'd4;
			end
			vatf_pkg::KF_RGBA4: begin
				v0 = vatf_pkg::chan_lut({4'd0, w16[15:12]}, 4'd4);
				v1 = vatf_pkg::chan_lut({4'd0, w16[11:8]}, 4'd4);
				v2 = vatf_pkg::chan_lut({4'd0, w16[7:4]}, 4'd4);
				v3 = vatf_pkg::chan_lut({4'd0, w16[3:0]}, 4'd4);
				bytes_used = 3'd2;
			end
			vatf_pkg::KF_RGBA6: begin
				v0 = vatf_pkg::chan_lut({2'd0, w24[23:18]}, 4'd6);
				v1 = vatf_pkg::chan_lut({2'd0, w24[17:12]}, 4'd6);
				v2 = vatf_pkg::chan_lut({2'd0, w24[11:6]}, 4'd6);
				v3 = vatf_pkg::chan_lut({2'd0, w24[5:0]}, 4'd6);
				bytes_used = 3'd3;
			end
			default: begin
				v0 = vatf_pkg::chan_lut(raw_bytes[31:24], 4'd8);
				v1 = vatf_pkg::chan_lut(raw_bytes[23:16], 4'd8);
				v2 = vatf_pkg::chan_lut(raw_bytes[15:8], 4'd8);
				v3 = vatf_pkg::chan_lut(raw_bytes[7:0], 4'd8);
				bytes_used = 3'd4;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/vertex_attribute_to_float_core.sv =====
// Each input beat passes the input register, then the result register, to become a result beat.
// Throughput: one beat per cycle while the output is not stalled; set by the single pass through the conversion logic.
// Result register keeps input accepted while a finished beat waits (skid-free stall
// by gating on the downstream side only when both stages are full).
// Reset: arst_n clears the valid flags of both stages; payloads are not reset.
// Depends on vatf_pkg, vatf_comp, vatf_color.
`default_nettype none
module vertex_attribute_to_float_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// opcode[0], raw_bytes[32:1], format[35:33], frac[40:36], zero fill
	input  wire logic [vatf_pkg::IN_W-1:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// value0[31:0], value1[63:32], value2[95:64], value3[127:96], bytes_used[130:128]
	output logic      [vatf_pkg::OUT_W-1:0] m_tdata
);
	vatf_pkg::item_t   in_s1;
	logic              vld_s1;
	vatf_pkg::result_t res_s2, res_d;
	logic              vld_s2;
	logic              adv_s2;
	logic [31:0]       cv;
	logic [2:0]        cb;
	logic [31:0]       k0, k1, k2, k3;
	logic [2:0]        kb;

	assign adv_s2   = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_s1.opcode    <= s_tdata[0];
			in_s1.raw_bytes <= s_tdata[32:1];
			in_s1.format    <= s_tdata[35:33];
			in_s1.frac      <= s_tdata[40:36];
		end
	end

	vatf_comp u_comp (
		.raw_bytes(in_s1.raw_bytes), .format(in_s1.format), .frac(in_s1.frac),
		.value(cv), .bytes_used(cb)
	);
	vatf_color u_color (
		.raw_bytes(in_s1.raw_bytes), .format(in_s1.format),
		.v0(k0), .v1(k1), .v2(k2), .v3(k3), .bytes_used(kb)
	);

	// result select
	always_comb begin
		if (in_s1.opcode == vatf_pkg::OP_COLOR) begin
			res_d = '{bytes_used: kb, value3: k3, value2: k2, value1: k1, value0: k0};
		end else begin
			res_d = '{bytes_used: cb, value3: 32'd0, value2: 32'd0, value1: 32'd0,
				value0: cv};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {5'd0, res_s2};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result moved");
	a_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[130:128] != 3'd0) else $error("bytes_used zero");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("stalled with empty output");
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for vertex_attribute_to_float_core: random and directed attribute beats,
// with results predicted bit for bit in the bench and checked in order.
// Depends on vatf_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;

	typedef struct {
		logic       opcode;
		logic [31:0] raw_bytes;
		logic [2:0] format;
		logic [4:0] frac;
		bit         drain;   // sender waits here until all results are back
		bit         quiet;   // no idling on either side for this beat
	} attr_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [47:0]   s_tdata = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [135:0]  m_tdata;

	attr_t         pending_attrs[$];
	vatf_pkg::result_t expected_floats[$];
	attr_t         in_flight;
	int unsigned   send_gap = 0;
	int unsigned   stall_left = 0;
	bit            quiet_mode = 1'b0;
	int unsigned   mismatches = 0;
	longint unsigned cycle_count = 0;

	vertex_attribute_to_float_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// exact IEEE single of a small signed integer times 2^-frac
	function automatic logic [31:0] int_to_single(input int v, input logic [4:0] frac);
		logic       sgn;
		int unsigned mag;
		int         msb;
		logic [31:0] mant;
		sgn = (v < 0);
		mag = sgn ? -v : v;
		if (mag == 0) return 32'd0;
		msb = 0;
		for (int i = 0; i < 32; i++) if (mag[i]) msb = i;
		mant = (mag << (23 - msb)) & 32'h007f_ffff;
		return {sgn, 8'(127 + msb - frac), mant[22:0]};
	endfunction

	// n/d correctly rounded to nearest (d odd, so no ties)
	function automatic logic [31:0] unorm_single(input int unsigned n, input int unsigned d);
		int        sh;
		longint unsigned num, m, rem;
		int        ex;
		if (n == 0) return 32'd0;
		sh = 0;
		while ((n << sh) < d) sh++;
		num = longint'(n) << (sh + 23);
		m = num / d;
		rem = num - m * d;
		if (2 * rem > d) m++;
		ex = 127 - sh;
		if (m == (64'd1 << 24)) begin
			m = m >> 1;
			ex++;
		end
		return {1'b0, 8'(ex), m[22:0]};
	endfunction

	function automatic vatf_pkg::result_t dequantize(input attr_t a);
		vatf_pkg::result_t r;
		logic [15:0] w;
		logic [23:0] w6;
		r = '0;
		w = a.raw_bytes[31:16];
		w6 = a.raw_bytes[31:8];
		if (a.opcode == vatf_pkg::OP_COMP) begin
			case (a.format)
				vatf_pkg::CF_U8: begin
					r.value0 = int_to_single(int'(a.raw_bytes[31:24]), a.frac);
					r.bytes_used = 3'd1;
				end
				vatf_pkg::CF_S8: begin
					r.value0 = int_to_single(int'($signed(a.raw_bytes[31:24])), a.frac);
					r.bytes_used = 3'd1;
				end
				vatf_pkg::CF_U16: begin
					r.value0 = int_to_single(int'(w), a.frac);
					r.bytes_used = 3'd2;
				end
				vatf_pkg::CF_S16: begin
					r.value0 = int_to_single(int'($signed(w)), a.frac);
					r.bytes_used = 3'd2;
				end
				default: begin
					r.value0 = a.raw_bytes;
					r.bytes_used = 3'd4;
				end
			endcase
		end else begin
			case (a.format)
				vatf_pkg::KF_RGB565: begin
					r.value0 = unorm_single(w[15:11], 31);
					r.value1 = unorm_single(w[10:5], 63);
					r.value2 = unorm_single(w[4:0], 31);
					r.value3 = vatf_pkg::FP_ONE;
					r.bytes_used = 3'd2;
				end
				vatf_pkg::KF_RGB8, vatf_pkg::KF_RGBX8: begin
					r.value0 = unorm_single(a.raw_bytes[31:24], 255);
					r.value1 = unorm_single(a.raw_bytes[23:16], 255);
					r.value2 = unorm_single(a.raw_bytes[15:8], 255);
					r.value3 = vatf_pkg::FP_ONE;
					r.bytes_used = (a.format == vatf_pkg::KF_RGB8) ? 3'd3 : 3'd4;
				end
				vatf_pkg::KF_RGBA4: begin
					r.value0 = unorm_single(w[15:12], 15);
					r.value1 = unorm_single(w[11:8], 15);
					r.value2 = unorm_single(w[7:4], 15);
					r.value3 = unorm_single(w[3:0], 15);
					r.bytes_used = 3'd2;
				end
				vatf_pkg::KF_RGBA6: begin
					r.value0 = unorm_single(w6[23:18], 63);
					r.value1 = unorm_single(w6[17:12], 63);
					r.value2 = unorm_single(w6[11:6], 63);
					r.value3 = unorm_single(w6[5:0], 63);
					r.bytes_used = 3'd3;
				end
				default: begin
					r.value0 = unorm_single(a.raw_bytes[31:24], 255);
					r.value1 = unorm_single(a.raw_bytes[23:16], 255);
					r.value2 = unorm_single(a.raw_bytes[15:8], 255);
					r.value3 = unorm_single(a.raw_bytes[7:0], 255);
					r.bytes_used = 3'd4;
				end
			endcase
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
		mismatches++;
	endtask

	task automatic queue_attr(input logic op, input logic [31:0] raw, input logic [2:0] fmt,
		input logic [4:0] frac, input bit quiet);
		attr_t a;
		a.opcode = op;
		a.raw_bytes = raw;
		a.format = fmt;
		a.frac = frac;
		a.drain = 1'b0;
		a.quiet = quiet;
		pending_attrs.push_back(a);
	endtask

	task automatic queue_drain();
		attr_t a;
		a = '{default: '0};
		a.drain = 1'b1;
		pending_attrs.push_back(a);
	endtask

	// driver: one beat at a time, random gap after each beat that is not quiet
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) expected_floats.push_back(dequantize(in_flight));
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_attrs.size() > 0 && pending_attrs[0].drain) begin
					if (expected_floats.size() == 0) void'(pending_attrs.pop_front());
					s_tvalid <= 1'b0;
				end else if (pending_attrs.size() > 0) begin
					in_flight = pending_attrs.pop_front();
					quiet_mode = in_flight.quiet;
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, in_flight.frac, in_flight.format,
						in_flight.raw_bytes, in_flight.opcode};
					send_gap <= in_flight.quiet ? 0 : $urandom_range(0, 6);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		vatf_pkg::result_t got, want;
		int unsigned wait_cycles;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[130:0];
				if (expected_floats.size() == 0) begin
					report("unexpected beat", got.value0, 32'd0);
				end else begin
					want = expected_floats.pop_front();
					if (got.value0 !== want.value0) report("value0", got.value0, want.value0);
					if (got.value1 !== want.value1) report("value1", got.value1, want.value1);
					if (got.value2 !== want.value2) report("value2", got.value2, want.value2);
					if (got.value3 !== want.value3) report("value3", got.value3, want.value3);
					if (got.bytes_used !== want.bytes_used)
						report("bytes_used", 32'(got.bytes_used), 32'(want.bytes_used));
				end
			end
			if (quiet_mode) begin
				m_tready <= 1'b1;
				stall_left <= 0;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (m_tvalid && m_tready) begin
				// idle for a random wait, possibly none, before taking the next beat
				wait_cycles = $urandom_range(0, 6);
				if (wait_cycles == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					stall_left <= wait_cycles - 1;
				end
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [2:0] fmt;
		// directed: component extremes
		queue_attr(vatf_pkg::OP_COMP, 32'h0000_0000, vatf_pkg::CF_U8, 5'd0, 1'b0);
		queue_attr(vatf_pkg::OP_COMP, 32'hff12_3456, vatf_pkg::CF_U8, 5'd31, 1'b0);
		queue_attr(vatf_pkg::OP_COMP, 32'h80ff_ffff, vatf_pkg::CF_S8, 5'd0, 1'b0);
		queue_attr(vatf_pkg::OP_COMP, 32'h7f00_0000, vatf_pkg::CF_S8, 5'd31, 1'b0);
		queue_attr(vatf_pkg::OP_COMP, 32'hffff_abcd, vatf_pkg::CF_U16, 5'd31, 1'b0);
		queue_attr(vatf_pkg::OP_COMP, 32'h8000_0000, vatf_pkg::CF_S16, 5'd0, 1'b0);
		queue_attr(vatf_pkg::OP_COMP, 32'hffff_0000, vatf_pkg::CF_S16, 5'd15, 1'b0);
		queue_attr(vatf_pkg::OP_COMP, 32'h7fc0_0001, 3'd4, 5'd7, 1'b0);    // NaN passes through
		queue_attr(vatf_pkg::OP_COMP, 32'hff80_0000, 3'd5, 5'd31, 1'b0);   // unused codes act as f32
		queue_attr(vatf_pkg::OP_COMP, 32'h3f80_0000, 3'd6, 5'd1, 1'b0);
		queue_attr(vatf_pkg::OP_COMP, 32'hdead_beef, 3'd7, 5'd0, 1'b0);
		// directed: every colour code, all-zero and all-one channels
		for (int f = 0; f < 8; f++) begin
			fmt = 3'(f);
			queue_attr(vatf_pkg::OP_COLOR, 32'h0000_0000, fmt, 5'd31, 1'b0);
			queue_attr(vatf_pkg::OP_COLOR, 32'hffff_ffff, fmt, 5'd0, 1'b0);
		end
		queue_drain();
		// random part, with a stretch of back-to-back beats and drain pauses
		for (int i = 0; i < 1300; i++) begin
			queue_attr(1'($urandom), $urandom, 3'($urandom_range(0, 7)),
				5'($urandom), (i >= 500 && i < 700));
			if (i % 400 == 399) queue_drain();
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_attrs.size() > 0 || s_tvalid || expected_floats.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/vatf_pkg.sv
rtl/core/vatf_comp.sv
rtl/core/vatf_color.sv
rtl/core/vertex_attribute_to_float_core.sv
tb/sv/testbench.sv
